>>> sv/htfe_pkg.sv
package htfe_pkg;

	localparam logic [7:0] HEAD_MARK = 8'hAA;
	localparam logic [7:0] TAIL_MARK = 8'h77;

	localparam int FRAME_DEPTH  = 32;
	localparam int IDX_W        = 5;
	localparam int CNT_W        = 6;
	localparam int LEN_W        = 5;
	localparam int STORE_AW     = IDX_W + 1;
	localparam int OVERHEAD     = 6;
	localparam int PAYLOAD_BASE = 4;

	typedef struct packed {
		logic                we;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          data;
	} store_wr_t;

	typedef struct packed {
		logic             ok;
		logic [7:0]       id;
		logic [LEN_W-1:0] len;
		logic             bank;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DATA,
		ST_OUT
	} back_state_t;

endpackage

>>> sv/htfe_ram.sv
module htfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/htfe_front.sv
module htfe_front #(
	parameter int BLOCK_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          data_byte,
	input  logic                end_of_block,
	input  logic                q_full,
	output logic                push,
	output htfe_pkg::job_t      job,
	output htfe_pkg::store_wr_t store_wr
);

	localparam int POS_W = $clog2(BLOCK_BYTES + 1);

	logic [7:0]                   prev_q;
	logic                         capturing_q;
	logic                         closed_q;
	logic [htfe_pkg::CNT_W-1:0]   count_q;
	logic                         ovf_q;
	logic [POS_W-1:0]             pos_q;
	logic                         bank_q;
	logic [7:0]                   id_q;
	logic [7:0]                   len_q;

	logic                         acc;
	logic                         scan;
	logic                         hdr;
	logic                         tail;
	logic                         cap_e;
	logic                         closed_e;
	logic                         ovf_e;
	logic [htfe_pkg::CNT_W-1:0]   cnt_e;
	logic                         wr;
	logic                         capturing_n;
	logic                         closed_n;
	logic                         ovf_n;
	logic [htfe_pkg::CNT_W-1:0]   cnt_n;
	logic [7:0]                   id_n;
	logic [7:0]                   len_n;
	logic                         ok;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;
	assign scan     = acc && (pos_q < POS_W'(BLOCK_BYTES));

	always_comb begin
		hdr      = (data_byte == htfe_pkg::HEAD_MARK) && (prev_q == htfe_pkg::HEAD_MARK);
		tail     = (data_byte == htfe_pkg::TAIL_MARK) && (prev_q == htfe_pkg::TAIL_MARK);
		cap_e    = hdr || capturing_q;
		closed_e = hdr ? 1'b0 : closed_q;
		ovf_e    = hdr ? 1'b0 : ovf_q;
		cnt_e    = hdr ? htfe_pkg::CNT_W'(1) : count_q;
		wr       = 1'b0;
		capturing_n = cap_e;
		closed_n    = closed_e;
		ovf_n       = ovf_e;
		cnt_n       = cnt_e;
		if (cap_e) begin
			if (cnt_e < htfe_pkg::CNT_W'(htfe_pkg::FRAME_DEPTH)) begin
				wr    = 1'b1;
				cnt_n = cnt_e + htfe_pkg::CNT_W'(1);
			end else begin
				ovf_n = 1'b1;
			end
			if (tail) begin
				capturing_n = 1'b0;
				closed_n    = 1'b1;
			end
		end
		id_n  = (wr && cnt_e == htfe_pkg::CNT_W'(2)) ? data_byte : id_q;
		len_n = (wr && cnt_e == htfe_pkg::CNT_W'(3)) ? data_byte : len_q;
		ok    = closed_n && !ovf_n && (cnt_n >= htfe_pkg::CNT_W'(4))
			&& (9'(cnt_n) == 9'(len_n) + 9'(htfe_pkg::OVERHEAD));
		if (!scan) begin
			closed_n = closed_q;
			ovf_n    = ovf_q;
			cnt_n    = count_q;
			id_n     = id_q;
			len_n    = len_q;
			ok       = closed_q && !ovf_q && (count_q >= htfe_pkg::CNT_W'(4))
				&& (9'(count_q) == 9'(len_q) + 9'(htfe_pkg::OVERHEAD));
		end
	end

	assign store_wr.we   = scan && wr;
	assign store_wr.addr = {bank_q, cnt_e[htfe_pkg::IDX_W-1:0]};
	assign store_wr.data = data_byte;

	assign push     = acc && end_of_block;
	assign job.ok   = ok;
	assign job.id   = ok ? id_n : 8'd0;
	assign job.len  = ok ? len_n[htfe_pkg::LEN_W-1:0] : '0;
	assign job.bank = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			capturing_q <= 1'b0;
			closed_q    <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			pos_q       <= '0;
			bank_q      <= 1'b0;
		end else if (push) begin
			prev_q      <= '0;
			capturing_q <= 1'b0;
			closed_q    <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			pos_q       <= '0;
			bank_q      <= !bank_q;
		end else if (scan) begin
			prev_q      <= data_byte;
			capturing_q <= capturing_n;
			closed_q    <= closed_n;
			count_q     <= cnt_n;
			ovf_q       <= ovf_n;
			pos_q       <= pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (scan) begin
			id_q  <= id_n;
			len_q <= len_n;
		end
	end

endmodule

>>> sv/htfe_queue.sv
module htfe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  htfe_pkg::job_t wr_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output htfe_pkg::job_t head
);

	htfe_pkg::job_t slot_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/htfe_back.sv
module htfe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  htfe_pkg::job_t                job,
	output logic                          pop,
	output logic [htfe_pkg::STORE_AW-1:0] raddr,
	input  logic [7:0]                    rdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);

	htfe_pkg::back_state_t state_q, state_d;
	logic [htfe_pkg::LEN_W-1:0] k_q, k_d;
	logic                       ld;
	logic                       multi;
	logic                       is_last;
	logic [7:0]                 id_o_q;
	logic [htfe_pkg::LEN_W-1:0] len_o_q;
	logic [7:0]                 byte_o_q;
	logic                       ok_o_q;
	logic                       last_o_q;

	assign multi   = job.ok && (job.len != '0);
	assign is_last = !multi || (k_q + htfe_pkg::LEN_W'(1) == job.len);

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		ld      = 1'b0;
		pop     = 1'b0;
		case (state_q)
			htfe_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (multi) begin
						state_d = htfe_pkg::ST_DATA;
					end else begin
						ld      = 1'b1;
						state_d = htfe_pkg::ST_OUT;
					end
				end
			end
			htfe_pkg::ST_DATA: begin
				ld      = 1'b1;
				state_d = htfe_pkg::ST_OUT;
			end
			htfe_pkg::ST_OUT: begin
				if (m_tready) begin
					if (last_o_q) begin
						pop     = 1'b1;
						k_d     = '0;
						state_d = htfe_pkg::ST_IDLE;
					end else begin
						k_d     = k_q + htfe_pkg::LEN_W'(1);
						state_d = htfe_pkg::ST_DATA;
					end
				end
			end
			default: begin
				state_d = htfe_pkg::ST_IDLE;
			end
		endcase
	end

	assign raddr = {job.bank, htfe_pkg::IDX_W'(k_d) + htfe_pkg::IDX_W'(htfe_pkg::PAYLOAD_BASE)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htfe_pkg::ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ok_o_q   <= job.ok;
			id_o_q   <= job.id;
			len_o_q  <= job.len;
			byte_o_q <= multi ? rdata : 8'd0;
			last_o_q <= is_last;
		end
	end

	assign m_tvalid = (state_q == htfe_pkg::ST_OUT);
	assign m_tdata  = {3'd0, byte_o_q, len_o_q, id_o_q};
	assign m_tuser  = ok_o_q;
	assign m_tlast  = last_o_q;

endmodule

>>> sv/header_tail_frame_extractor.sv
// Header/tail byte frame extractor.
// Slave stream: one raw byte per item in s_tdata[7:0]; s_tlast marks the
// final byte of a block. Bytes past BLOCK_BYTES in a block are not scanned.
// Master stream: per block either one reject item (m_tuser low, fields zero)
// or the accepted frame: m_tuser high, ID and length, one item per payload
// byte (a single item when the length is zero), m_tlast on the final item.
// Throughput: the front end takes one byte per cycle while s_tready is high. Captured bytes go to a
// two-bank frame store and each block end posts a job to a two-entry queue,
// so the next block streams in while the previous frame is read out.
// Read-out: the s_tlast byte's job is registered in the queue; the back end
// then loads the output registers and raises m_tvalid. Each payload item
// is first fetched in a read state, set by the registered read of the frame
// store, so payload items do not come back to back. With both banks pending,
// s_tready drops until the back end finishes a job.
// Reset clears the scanner state and the job queue; the store holds no valid
// data until written. A stalled receiver holds the current item on m_tdata.
module header_tail_frame_extractor #(
	parameter int BLOCK_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_block
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] frame_id, [12:8] payload_len, [20:13] payload_byte
	output logic        m_tuser,   // frame_ok
	output logic        m_tlast    // last
);

	htfe_pkg::store_wr_t             store_wr;
	htfe_pkg::job_t                  push_job;
	htfe_pkg::job_t                  head_job;
	logic                            push;
	logic                            pop;
	logic                            q_full;
	logic                            q_valid;
	logic [htfe_pkg::STORE_AW-1:0]   raddr;
	logic [7:0]                      rdata;

	htfe_front #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.data_byte   (s_tdata),
		.end_of_block(s_tlast),
		.q_full      (q_full),
		.push        (push),
		.job         (push_job),
		.store_wr    (store_wr)
	);

	htfe_ram #(
		.WIDTH(8),
		.DEPTH(2 * htfe_pkg::FRAME_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_wr.we),
		.waddr(store_wr.addr),
		.wdata(store_wr.data),
		.raddr(raddr),
		.rdata(rdata)
	);

	htfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (push_job),
		.pop      (pop),
		.full     (q_full),
		.not_empty(q_valid),
		.head     (head_job)
	);

	htfe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.job     (head_job),
		.pop     (pop),
		.raddr   (raddr),
		.rdata   (rdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int BLOCK_BYTES = 32;
	localparam int HOLD_CYCLES = 600;
	localparam int STALL_LIMIT = 4000;

	typedef enum logic [2:0] {
		PH_FREE,
		PH_TX,
		PH_RX,
		PH_BOTH,
		PH_HOLD
	} load_phase_t;

	typedef struct {
		logic [7:0]  data;
		logic        eob;
		load_phase_t ph;
		logic        drain;
	} rx_byte_t;

	typedef struct packed {
		logic                       ok;
		logic [7:0]                 id;
		logic [htfe_pkg::LEN_W-1:0] len;
		logic [7:0]                 pbyte;
		logic                       last;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	header_tail_frame_extractor #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	rx_byte_t      byte_q[$];
	frame_result_t frame_results[$];
	logic [7:0]    blk[$];
	load_phase_t   gen_ph = PH_FREE;
	logic          gen_drain = 1'b0;
	int            n_queued = 0;
	load_phase_t   cur_ph = PH_FREE;
	int            err_cnt = 0;
	int            hold_left = 0;
	logic          hold_done = 1'b0;
	int            quiet_cycles = 0;
	rx_byte_t      nxt;
	frame_result_t want;

	// scanner copy
	logic [7:0] prev_byte;
	logic       in_capture;
	logic       closed;
	int         cap_count;
	logic       cap_ovf;
	logic [7:0] cap_store [htfe_pkg::FRAME_DEPTH];
	int         blk_pos;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic clear_scanner();
		prev_byte  = '0;
		in_capture = 1'b0;
		closed     = 1'b0;
		cap_count  = 0;
		cap_ovf    = 1'b0;
		blk_pos    = 0;
	endtask

	task automatic scan_byte(input logic [7:0] d);
		if (d == htfe_pkg::HEAD_MARK && prev_byte == htfe_pkg::HEAD_MARK) begin
			in_capture   = 1'b1;
			closed       = 1'b0;
			cap_ovf      = 1'b0;
			cap_store[0] = htfe_pkg::HEAD_MARK;
			cap_count    = 1;
		end
		if (in_capture) begin
			if (cap_count < htfe_pkg::FRAME_DEPTH) begin
				cap_store[cap_count] = d;
				cap_count++;
			end else begin
				cap_ovf = 1'b1;
			end
			if (d == htfe_pkg::TAIL_MARK && prev_byte == htfe_pkg::TAIL_MARK) begin
				in_capture = 1'b0;
				closed     = 1'b1;
			end
		end
		prev_byte = d;
	endtask

	task automatic predict_byte(input logic [7:0] d, input logic eob);
		logic          ok;
		int            flen;
		frame_result_t r;
		ok   = 1'b0;
		flen = 0;
		if (blk_pos < BLOCK_BYTES) begin
			blk_pos++;
			scan_byte(d);
		end
		if (eob) begin
			if (closed && !cap_ovf && cap_count >= 4) begin
				flen = cap_store[3];
				ok   = (cap_count == flen + htfe_pkg::OVERHEAD);
			end
			if (!ok) begin
				r = '{ok: 1'b0, id: '0, len: '0, pbyte: '0, last: 1'b1};
				frame_results.push_back(r);
			end else if (flen == 0) begin
				r = '{ok: 1'b1, id: cap_store[2], len: '0, pbyte: '0, last: 1'b1};
				frame_results.push_back(r);
			end else begin
				for (int k = 0; k < flen; k++) begin
					r.ok    = 1'b1;
					r.id    = cap_store[2];
					r.len   = flen[htfe_pkg::LEN_W-1:0];
					r.pbyte = cap_store[(htfe_pkg::PAYLOAD_BASE + k) % htfe_pkg::FRAME_DEPTH];
					r.last  = (k + 1 == flen);
					frame_results.push_back(r);
				end
			end
			clear_scanner();
		end
	endtask

	function automatic int tx_idle_pct(input load_phase_t ph);
		case (ph)
			PH_TX:   return 85;
			PH_BOTH: return 8;
			default: return 0;
		endcase
	endfunction

	function automatic int rx_stall_pct(input load_phase_t ph);
		case (ph)
			PH_RX:   return 85;
			PH_BOTH: return 8;
			default: return 0;
		endcase
	endfunction

	task automatic cmp_field(input string fname, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
		end
	endtask

	// stimulus building
	task automatic flush_block();
		rx_byte_t it;
		for (int i = 0; i < blk.size(); i++) begin
			it.data  = blk[i];
			it.eob   = (i == blk.size() - 1);
			it.ph    = gen_ph;
			it.drain = gen_drain;
			gen_drain = 1'b0;
			byte_q.push_back(it);
			n_queued++;
		end
		blk.delete();
	endtask

	task automatic send_bytes(input logic [127:0] seq, input int n);
		for (int i = 0; i < n; i++)
			blk.push_back(seq[8*(n-1-i) +: 8]);
		flush_block();
	endtask

	task automatic add_junk(input int n);
		for (int i = 0; i < n; i++)
			blk.push_back(8'($urandom_range(255)));
	endtask

	task automatic gen_block();
		int kind, flen, fld, pre, post, n, r;
		kind = $urandom_range(99);
		if (kind < 80) begin
			if (kind < 70)
				flen = ($urandom_range(3) == 0) ? $urandom_range(20, 26) : $urandom_range(0, 12);
			else
				flen = $urandom_range(0, 8);
			fld = flen;
			if ($urandom_range(9) == 0)
				fld = ($urandom_range(1) == 0) ? flen + 1 : $urandom_range(255);
			pre  = $urandom_range(0, (26 - flen) > 3 ? 3 : 26 - flen);
			post = $urandom_range(0, (26 - flen - pre) > 2 ? 2 : 26 - flen - pre);
			add_junk(pre);
			blk.push_back(htfe_pkg::HEAD_MARK);
			blk.push_back(htfe_pkg::HEAD_MARK);
			blk.push_back(8'($urandom_range(255)));
			blk.push_back(8'(fld));
			add_junk(flen);
			r = $urandom_range(9);
			if (r != 0) begin
				blk.push_back(htfe_pkg::TAIL_MARK);
				blk.push_back(htfe_pkg::TAIL_MARK);
			end
			// broken: header after the tail voids the frame
			if (r == 1) begin
				blk.push_back(htfe_pkg::HEAD_MARK);
				blk.push_back(htfe_pkg::HEAD_MARK);
			end
			add_junk(post);
			if (kind >= 70) begin
				// long block, header marks past the scan window are ignored
				n = $urandom_range(BLOCK_BYTES + 1, BLOCK_BYTES + 8);
				while (blk.size() < n) begin
					if (blk.size() >= BLOCK_BYTES && $urandom_range(1) == 0)
						blk.push_back(htfe_pkg::HEAD_MARK);
					else
						blk.push_back(8'($urandom_range(255)));
				end
			end
		end else begin
			n = $urandom_range(1, 40);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(3);
				blk.push_back(r == 0 ? htfe_pkg::HEAD_MARK :
					r == 1 ? htfe_pkg::TAIL_MARK : 8'($urandom_range(255)));
			end
		end
		flush_block();
	endtask

	task automatic run_phase(input load_phase_t ph, input int nbytes);
		int start;
		gen_ph    = ph;
		gen_drain = 1'b1;
		start     = n_queued;
		while (n_queued - start < nbytes)
			gen_block();
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (byte_q.size() > 0 && (!byte_q[0].drain || frame_results.size() == 0)
						&& $urandom_range(99) >= tx_idle_pct(byte_q[0].ph)) begin
					nxt = byte_q.pop_front();
					cur_ph   <= nxt.ph;
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.data;
					s_tlast  <= nxt.eob;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (frame_results.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected item, expected none, actual ok=%0b data=%h last=%0b",
						$time, m_tuser, m_tdata, m_tlast);
				end else begin
					want = frame_results.pop_front();
					cmp_field("frame_ok", want.ok, m_tuser);
					cmp_field("frame_id", want.id, m_tdata[7:0]);
					cmp_field("payload_len", want.len, m_tdata[12:8]);
					cmp_field("payload_byte", want.pbyte, m_tdata[20:13]);
					cmp_field("last", want.last, m_tlast);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (cur_ph == PH_HOLD && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct(cur_ph));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		clear_scanner();
		for (int i = 0; i < htfe_pkg::FRAME_DEPTH; i++)
			cap_store[i] = '0;

		// directed
		gen_ph = PH_FREE;
		send_bytes(48'hAAAA00007777, 6);         // zero length, zero id
		send_bytes(56'hAAAAFF01FF7777, 7);       // all-ones id and payload
		send_bytes(8'h00, 1);                    // lone end mark
		send_bytes(56'hAAAAAA12007777, 7);       // triple header byte
		send_bytes(64'hAAAA05007777AAAA, 8);     // later header voids closed frame
		send_bytes(8'hAA, 1);                    // header split across blocks
		send_bytes(40'hAA07007777, 5);

		run_phase(PH_FREE, 70);
		run_phase(PH_TX, 70);
		run_phase(PH_RX, 70);
		run_phase(PH_BOTH, 70);
		run_phase(PH_HOLD, 90);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() > 0 || s_tvalid)
			@(posedge clk);
		while (frame_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
sv/htfe_pkg.sv
sv/htfe_ram.sv
sv/htfe_front.sv
sv/htfe_queue.sv
sv/htfe_back.sv
sv/header_tail_frame_extractor.sv
dv/tb_top.sv
